### rtl/core/lzbd_pkg.sv
package lzbd_pkg;

  localparam int unsigned      HISTORY_DEPTH_DEF = 4096;
  localparam logic [15:0]      MAX_OUTPUT_DEF    = 16'hC800;

  localparam int               BYTE_W      = 8;
  localparam int               CNT_W       = 16;
  localparam int               LEN_W       = 5;
  localparam int               OFF_W       = 12;
  localparam int               STATUS_W    = 2;
  localparam int               OUT_TDATA_W = 32;

  localparam logic [LEN_W-1:0] LEN_BIAS       = 5'd3;
  localparam logic [3:0]       FLAGS_PER_CTRL = 4'd8;
  localparam logic [CNT_W-1:0] HDR_BIAS       = 16'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [4:0] {
    PH_HDR_LO     = 5'b00001,
    PH_HDR_HI     = 5'b00010,
    PH_CONTROL    = 5'b00100,
    PH_ITEM       = 5'b01000,
    PH_REF_SECOND = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_COPY = 2'b10
  } ctrl_state_t;

  typedef struct packed {
    logic accept;      // input transfer this cycle, decode and maybe issue first byte
    logic copy_issue;  // issue the next byte of a running copy
  } lzbd_cmd_t;

  typedef struct packed {
    logic stage_free;  // read stage empty or moving on this cycle
    logic dec_multi;   // current input yields two or more bytes
    logic rem_last;    // running copy has one byte left
  } lzbd_sts_t;

endpackage

### rtl/core/lzbd_ctrl.sv
module lzbd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  lzbd_pkg::lzbd_sts_t sts,
  output lzbd_pkg::lzbd_cmd_t cmd
);
  import lzbd_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready  = sts.stage_free;
        cmd.accept = in_tvalid && sts.stage_free;
        if (cmd.accept && sts.dec_multi) begin
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy_issue = sts.stage_free;
        if (sts.stage_free && sts.rem_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/lzbd_datapath.sv
module lzbd_datapath #(
  parameter int unsigned HISTORY_DEPTH = lzbd_pkg::HISTORY_DEPTH_DEF,
  parameter logic [15:0] MAX_OUTPUT    = lzbd_pkg::MAX_OUTPUT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [lzbd_pkg::CNT_W-1:0]          cfg_wr_data,
  input  logic [lzbd_pkg::BYTE_W-1:0]         in_tdata,
  input  logic                                in_tlast,
  input  lzbd_pkg::lzbd_cmd_t                 cmd,
  output lzbd_pkg::lzbd_sts_t                 sts,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [lzbd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast,
  output logic                                out_tuser
);
  import lzbd_pkg::*;

  // depth must be a power of two so the address wraps with the count (the block does not check it)
  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int PAD_W = OUT_TDATA_W - CNT_W - STATUS_W - BYTE_W;

  // stream parse state
  phase_t             phase_r;
  logic [BYTE_W-1:0]  flag_byte_r;
  logic [3:0]         flags_left_r;
  logic [BYTE_W-1:0]  ref_first_r;
  logic [CNT_W-1:0]   header_r;
  logic [CNT_W-1:0]   in_cnt_r;
  logic               ovf_r;
  logic [CNT_W-1:0]   max_r;

  // issue side
  logic [CNT_W-1:0]    cnt_r;
  logic [LEN_W-1:0]    rem_r;
  logic [AW-1:0]       rd_addr_r;
  logic                mode_mem_r;
  logic                final_in_r;
  logic [STATUS_W-1:0] final_st_r;
  logic                ovf_prev_r;

  // read stage
  logic                stg_valid_r;
  logic                stg_mem_r;
  logic [BYTE_W-1:0]   stg_val_r;
  logic                stg_has_r;
  logic                stg_last_r;
  logic [STATUS_W-1:0] stg_status_r;
  logic [CNT_W-1:0]    stg_total_r;
  logic [AW-1:0]       stg_waddr_r;

  logic [BYTE_W-1:0]   hist_mem [HISTORY_DEPTH];
  logic [BYTE_W-1:0]   hist_q_r;
  logic                byp_r;
  logic [BYTE_W-1:0]   byp_data_r;

  // output register
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic                out_has_r;
  logic                out_last_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [CNT_W-1:0]    out_total_r;

  // decode
  logic [CNT_W-1:0]    in_cnt_nxt;
  logic [CNT_W-1:0]    header_nxt;
  phase_t              phase_nxt;
  logic [BYTE_W-1:0]   flag_nxt;
  logic [3:0]          left_nxt;
  logic [BYTE_W-1:0]   ref_first_nxt;
  logic [LEN_W-1:0]    dec_len;
  logic [LEN_W-1:0]    dec_k;
  logic                dec_mem;
  logic [BYTE_W-1:0]   dec_val;
  logic                dec_ovf_add;
  logic                mismatch;
  logic [STATUS_W-1:0] final_st;

  logic [BYTE_W-1:0]   flag_shift;
  logic [3:0]          left_dec;
  phase_t              ph_after;

  logic [OFF_W-1:0]    off_raw;
  logic                off_far;
  logic [CNT_W-1:0]    off_sel;
  logic                ref_valid;
  logic [CNT_W-1:0]    ref_back;
  logic [AW-1:0]       ref_addr;
  logic [LEN_W-1:0]    ref_len;
  logic                full;
  logic [CNT_W-1:0]    room;

  // issue mux
  logic                issue;
  logic [LEN_W-1:0]    iss_n;
  logic                iss_mem;
  logic [BYTE_W-1:0]   iss_val;
  logic [AW-1:0]       iss_addr;
  logic                iss_final;
  logic [STATUS_W-1:0] iss_fst;
  logic                iss_ovf;
  logic                iss_has;
  logic                iss_last;
  logic [STATUS_W-1:0] iss_status;
  logic [CNT_W-1:0]    iss_total;

  logic                adv;
  logic                hist_we;
  logic                hist_re;
  logic [BYTE_W-1:0]   stg_data;

  assign flag_shift = {flag_byte_r[BYTE_W-2:0], 1'b0};
  assign left_dec   = (flags_left_r != 4'd0) ? flags_left_r - 4'd1 : 4'd0;
  assign ph_after   = (left_dec == 4'd0) ? PH_CONTROL : PH_ITEM;

  // offset too far back falls back to its low nibble
  assign off_raw   = {in_tdata, ref_first_r[BYTE_W-1:4]};
  assign off_far   = {{(CNT_W-OFF_W){1'b0}}, off_raw} >= cnt_r;
  assign off_sel   = off_far ? {{(CNT_W-4){1'b0}}, off_raw[3:0]}
                             : {{(CNT_W-OFF_W){1'b0}}, off_raw};
  assign ref_valid = off_sel < cnt_r;
  assign ref_back  = cnt_r - off_sel - 16'd1;
  assign ref_addr  = ref_back[AW-1:0];
  assign ref_len   = {1'b0, ref_first_r[3:0]} + LEN_BIAS;

  assign full = cnt_r >= max_r;
  assign room = max_r - cnt_r;

  always_comb begin
    in_cnt_nxt    = in_cnt_r + 16'd1;
    header_nxt    = header_r;
    phase_nxt     = phase_r;
    flag_nxt      = flag_byte_r;
    left_nxt      = flags_left_r;
    ref_first_nxt = ref_first_r;
    dec_len       = '0;
    dec_mem       = 1'b0;
    dec_val       = in_tdata;
    unique case (phase_r)
      PH_HDR_LO: begin
        header_nxt = {{(CNT_W-BYTE_W){1'b0}}, in_tdata};
        phase_nxt  = PH_HDR_HI;
      end
      PH_HDR_HI: begin
        header_nxt = {in_tdata, header_r[BYTE_W-1:0]};
        phase_nxt  = PH_CONTROL;
      end
      PH_CONTROL: begin
        flag_nxt  = in_tdata;
        left_nxt  = FLAGS_PER_CTRL;
        phase_nxt = PH_ITEM;
      end
      PH_ITEM: begin
        // a reference cut off by the end of stream becomes a literal
        if (flag_byte_r[BYTE_W-1] || in_tlast) begin
          dec_len   = 5'd1;
          flag_nxt  = flag_shift;
          left_nxt  = left_dec;
          phase_nxt = ph_after;
        end else begin
          ref_first_nxt = in_tdata;
          phase_nxt     = PH_REF_SECOND;
        end
      end
      PH_REF_SECOND: begin
        dec_len   = ref_len;
        dec_mem   = ref_valid;
        dec_val   = '0;
        flag_nxt  = flag_shift;
        left_nxt  = left_dec;
        phase_nxt = ph_after;
      end
      default: phase_nxt = PH_HDR_LO;
    endcase

    // bytes past the output limit are dropped
    if (full) begin
      dec_k = '0;
    end else if (room < {{(CNT_W-LEN_W){1'b0}}, dec_len}) begin
      dec_k = room[LEN_W-1:0];
    end else begin
      dec_k = dec_len;
    end
    dec_ovf_add = dec_k != dec_len;

    mismatch = (phase_nxt == PH_HDR_LO) || (phase_nxt == PH_HDR_HI) ||
               ((header_nxt + HDR_BIAS) != in_cnt_nxt);
    if (mismatch) begin
      final_st = ST_MISMATCH;
    end else if (ovf_r || dec_ovf_add) begin
      final_st = ST_OVERFLOW;
    end else begin
      final_st = ST_OK;
    end
  end

  assign adv      = stg_valid_r && (!out_valid_r || out_tready);
  assign stg_data = stg_mem_r ? (byp_r ? byp_data_r : hist_q_r) : stg_val_r;
  assign hist_we  = adv && stg_has_r;

  always_comb begin
    if (cmd.copy_issue) begin
      iss_n     = rem_r;
      iss_mem   = mode_mem_r;
      iss_val   = '0;
      iss_addr  = rd_addr_r;
      iss_final = final_in_r;
      iss_fst   = final_st_r;
      iss_ovf   = ovf_prev_r;
    end else begin
      // a status-only result carries a zero byte
      iss_n     = dec_k;
      iss_mem   = dec_mem && (dec_k != '0);
      iss_val   = (dec_k != '0) ? dec_val : '0;
      iss_addr  = ref_addr;
      iss_final = in_tlast;
      iss_fst   = final_st;
      iss_ovf   = ovf_r;
    end
    // end of stream with no byte gives a status-only result
    issue      = cmd.copy_issue || (cmd.accept && ((dec_k != '0) || in_tlast));
    iss_has    = iss_n != '0;
    iss_last   = iss_n <= 5'd1;
    iss_status = (iss_last && iss_final) ? iss_fst : (iss_ovf ? ST_OVERFLOW : ST_OK);
    iss_total  = cnt_r + {{(CNT_W-1){1'b0}}, iss_has};
  end

  assign hist_re = issue && iss_mem;

  assign sts.stage_free = !stg_valid_r || adv;
  assign sts.dec_multi  = dec_k > 5'd1;
  assign sts.rem_last   = rem_r == 5'd1;

  // parse state and limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR_LO;
      flag_byte_r  <= '0;
      flags_left_r <= '0;
      ref_first_r  <= '0;
      header_r     <= '0;
      in_cnt_r     <= '0;
      ovf_r        <= 1'b0;
      max_r        <= MAX_OUTPUT;
    end else begin
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      if (cmd.accept) begin
        if (in_tlast) begin
          phase_r      <= PH_HDR_LO;
          flag_byte_r  <= '0;
          flags_left_r <= '0;
          ref_first_r  <= '0;
          header_r     <= '0;
          in_cnt_r     <= '0;
          ovf_r        <= 1'b0;
        end else begin
          phase_r      <= phase_nxt;
          flag_byte_r  <= flag_nxt;
          flags_left_r <= left_nxt;
          ref_first_r  <= ref_first_nxt;
          header_r     <= header_nxt;
          in_cnt_r     <= in_cnt_nxt;
          ovf_r        <= ovf_r || dec_ovf_add;
        end
      end
    end
  end

  // output count moves at issue; the stage carries its own address and total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (issue) begin
      cnt_r <= (iss_last && iss_final) ? '0 : iss_total;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rem_r      <= dec_k - 5'd1;
      rd_addr_r  <= ref_addr + 1'b1;
      mode_mem_r <= dec_mem;
      final_in_r <= in_tlast;
      final_st_r <= final_st;
      ovf_prev_r <= ovf_r;
    end else if (cmd.copy_issue) begin
      rem_r     <= rem_r - 5'd1;
      rd_addr_r <= rd_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (issue) begin
      stg_valid_r <= 1'b1;
    end else if (adv) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      stg_mem_r    <= iss_mem;
      stg_val_r    <= iss_val;
      stg_has_r    <= iss_has;
      stg_last_r   <= iss_last;
      stg_status_r <= iss_status;
      stg_total_r  <= iss_total;
      stg_waddr_r  <= cnt_r[AW-1:0];
    end
  end

  // history: write on stage retire, registered read; a read of the entry
  // written in the same cycle takes the new byte
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[stg_waddr_r] <= stg_data;
    end
    if (hist_re) begin
      hist_q_r   <= hist_mem[iss_addr];
      byp_r      <= hist_we && (stg_waddr_r == iss_addr);
      byp_data_r <= stg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r   <= stg_data;
      out_has_r    <= stg_has_r;
      out_last_r   <= stg_last_r;
      out_status_r <= stg_status_r;
      out_total_r  <= stg_total_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_total_r, out_status_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_has_r;

endmodule

### rtl/core/lzss_byte_decompressor.sv
// channel  dir  ports                    contents
// in       in   in_tvalid/tready/tdata   tdata[7:0] byte, tlast end of stream
// out      out  out_tvalid/tready/tdata  tdata byte/status/count, tlast, tuser
// cfg      in   cfg_wr_en/cfg_wr_data    output length limit
//
// A literal issues one byte; a reference issues up to 18, one history read per
// cycle through a single read port while the read stage is free. No clearing
// pass after reset. A stalled output holds the read stage and with it the
// input side.
module lzss_byte_decompressor #(
  parameter int unsigned HISTORY_DEPTH = lzbd_pkg::HISTORY_DEPTH_DEF,
  parameter logic [15:0] MAX_OUTPUT    = lzbd_pkg::MAX_OUTPUT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [lzbd_pkg::CNT_W-1:0]       cfg_wr_data,  // max_output_length
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lzbd_pkg::BYTE_W-1:0]      in_tdata,     // [7:0] in_byte
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] out_byte, [9:8] status, [25:10] total_count, [31:26] zero
  output logic [lzbd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast,
  output logic                             out_tuser     // [0] out_has_byte
);
  import lzbd_pkg::*;

  lzbd_cmd_t cmd;
  lzbd_sts_t sts;

  lzbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lzbd_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_OUTPUT    (MAX_OUTPUT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  a_no_accept_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.copy_issue && in_tready))
    else $error("input taken while a copy is running");

  a_status_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("status-only result not marked last");

  a_mismatch_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[9:8] != ST_MISMATCH))
    else $error("mismatch status on a result that is not last");

  a_data_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[25:10] != '0))
    else $error("data result with zero total count");

endmodule

### bench/lzss_byte_decompressor_tb.sv
module lzss_byte_decompressor_tb;
  import lzbd_pkg::*;

  localparam int HIST_DEPTH       = HISTORY_DEPTH_DEF;
  localparam int MAX_STEP_RESULTS = 18;
  localparam int RANDOM_ITEMS     = 110;
  localparam int SETTLE_CYCLES    = 40;
  localparam int LONG_HOLD        = 400;
  localparam int WATCHDOG_CYCLES  = 3000;
  localparam int REPORT_CAP       = 60;

  typedef struct packed {
    logic [7:0]          data;
    logic                has_byte;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    total;
  } dec_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;

  lzss_byte_decompressor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  always #2 clk = ~clk;

  // decoder shadow state
  logic [7:0]       hist_mem [HIST_DEPTH];
  logic [CNT_W-1:0] out_limit;
  logic [CNT_W-1:0] out_cnt;
  logic [CNT_W-1:0] in_cnt;
  logic [CNT_W-1:0] hdr_len;
  phase_t           dec_phase;
  logic [7:0]       flag_bits;
  logic [3:0]       flags_left;
  logic [7:0]       ref_lo;
  bit               ovf_seen;

  dec_result_t pending_out[$];
  dec_result_t step_out[$];
  logic [7:0]  body_q[$];

  int mismatch_count = 0;
  int sent_items = 0;
  int quiet_cycles = 0;
  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;
  bit long_hold_req = 1'b0;
  bit long_hold_taken = 1'b0;
  int stall_left = 0;

  function automatic void clear_stream();
    out_cnt = '0;
    in_cnt = '0;
    hdr_len = '0;
    dec_phase = PH_HDR_LO;
    flag_bits = '0;
    flags_left = '0;
    ref_lo = '0;
    ovf_seen = 1'b0;
  endfunction

  function automatic void emit_byte(input logic [7:0] v);
    dec_result_t r;
    if (out_cnt >= out_limit || step_out.size() >= MAX_STEP_RESULTS) begin
      ovf_seen = 1'b1;
      return;
    end
    hist_mem[out_cnt % HIST_DEPTH] = v;
    out_cnt = out_cnt + 16'd1;
    r.data = v;
    r.has_byte = 1'b1;
    r.last = 1'b0;
    r.status = ovf_seen ? ST_OVERFLOW : ST_OK;
    r.total = out_cnt;
    step_out.push_back(r);
  endfunction

  function automatic void advance_flag();
    flag_bits = {flag_bits[6:0], 1'b0};
    if (flags_left != 0) flags_left = flags_left - 4'd1;
    if (flags_left == 0) dec_phase = PH_CONTROL;
    else dec_phase = PH_ITEM;
  endfunction

  // Expected results for one accepted stream byte, appended to pending_out.
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    int dist_off, copy_len, oc, k;
    bit src_ok, hdr_bad;
    dec_result_t r;
    step_out.delete();
    in_cnt = in_cnt + 16'd1;
    case (dec_phase)
      PH_HDR_LO: begin
        hdr_len = {8'h00, b};
        dec_phase = PH_HDR_HI;
      end
      PH_HDR_HI: begin
        hdr_len[15:8] = b;
        dec_phase = PH_CONTROL;
      end
      PH_CONTROL: begin
        flag_bits = b;
        flags_left = FLAGS_PER_CTRL;
        dec_phase = PH_ITEM;
      end
      PH_ITEM: begin
        // a reference cut off by end of stream counts as a literal
        if (flag_bits[7] || last) begin
          emit_byte(b);
          advance_flag();
        end else begin
          ref_lo = b;
          dec_phase = PH_REF_SECOND;
        end
      end
      PH_REF_SECOND: begin
        dist_off = {b, ref_lo[7:4]};
        copy_len = int'(ref_lo[3:0]) + int'(LEN_BIAS);
        oc = out_cnt;
        if (dist_off + 1 > oc) dist_off = dist_off % 16;
        src_ok = (dist_off + 1 <= oc);
        // byte by byte so overlapping copies see their own output
        for (k = 0; k < copy_len; k++) begin
          oc = out_cnt;
          emit_byte(src_ok ? hist_mem[(oc - dist_off - 1) % HIST_DEPTH] : 8'h00);
        end
        advance_flag();
      end
      default: dec_phase = PH_HDR_LO;
    endcase
    if (last) begin
      hdr_bad = (dec_phase == PH_HDR_LO) || (dec_phase == PH_HDR_HI) ||
                ((hdr_len + HDR_BIAS) != in_cnt);
      if (step_out.size() == 0) begin
        r.data = '0;
        r.has_byte = 1'b0;
        r.last = 1'b0;
        r.status = ST_OK;
        r.total = out_cnt;
        step_out.push_back(r);
      end
      step_out[step_out.size()-1].last = 1'b1;
      step_out[step_out.size()-1].status =
        hdr_bad ? ST_MISMATCH : (ovf_seen ? ST_OVERFLOW : ST_OK);
      clear_stream();
    end else if (step_out.size() != 0) begin
      step_out[step_out.size()-1].last = 1'b1;
    end
    foreach (step_out[i]) pending_out.push_back(step_out[i]);
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      if (mismatch_count < REPORT_CAP)
        $display("%0t %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    dec_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_out.size() == 0) begin
        if (mismatch_count < REPORT_CAP)
          $display("%0t unexpected transfer: expected none, actual tdata %h tlast %b tuser %b",
                   $time, out_tdata, out_tlast, out_tuser);
        mismatch_count++;
      end else begin
        want = pending_out.pop_front();
        check_field("out_byte", want.data, out_tdata[7:0]);
        check_field("out_has_byte", want.has_byte, out_tuser);
        check_field("out_last", want.last, out_tlast);
        check_field("status", want.status, out_tdata[9:8]);
        check_field("total_count", want.total, out_tdata[25:10]);
      end
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  always @(posedge clk) begin
    if (long_hold_req && !long_hold_taken) begin
      long_hold_taken = 1'b1;
      stall_left = LONG_HOLD;
    end else if (stall_left == 0 && rx_gaps && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18);
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL lzss_byte_decompressor");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, last);
    sent_items++;
  endtask

  task automatic send_raw();
    int i;
    for (i = 0; i < body_q.size(); i++) send_byte(body_q[i], i == body_q.size() - 1);
  endtask

  task automatic send_framed(input bit good_hdr);
    logic [15:0] hdr;
    int i;
    hdr = good_hdr ? 16'(body_q.size()) : 16'($urandom_range(0, 65535));
    send_byte(hdr[7:0], 1'b0);
    send_byte(hdr[15:8], body_q.size() == 0);
    for (i = 0; i < body_q.size(); i++) send_byte(body_q[i], i == body_q.size() - 1);
  endtask

  // wait for all results plus a margin so no copy is still running
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    out_limit = v;
  endtask

  // control bytes plus items; offsets mostly reach back into bytes already made
  task automatic build_body(input int n_items, input int ref_pct, input int wild_pct,
                            input bit full_len);
    int k, ctrl_at, made, span;
    logic [11:0] off;
    logic [3:0] len_code;
    body_q.delete();
    made = 0;
    ctrl_at = 0;
    for (k = 0; k < n_items; k++) begin
      if (k % 8 == 0) begin
        ctrl_at = body_q.size();
        body_q.push_back(8'h00);
      end
      if ($urandom_range(0, 99) < ref_pct) begin
        len_code = full_len ? 4'hF : 4'($urandom_range(0, 15));
        span = (made == 0) ? 16 : ((made > HIST_DEPTH) ? HIST_DEPTH : made);
        if ($urandom_range(0, 99) < wild_pct) off = 12'($urandom_range(0, 4095));
        else off = 12'($urandom_range(0, span - 1));
        body_q.push_back({off[3:0], len_code});
        body_q.push_back(off[11:4]);
        made += int'(len_code) + 3;
      end else begin
        body_q[ctrl_at] = body_q[ctrl_at] | (8'h80 >> (k % 8));
        body_q.push_back(8'($urandom_range(0, 255)));
        made++;
      end
    end
  endtask

  task automatic test_directed_frames();
    tx_gaps = 1'b1;
    rx_gaps <= 1'b1;
    // folded offset still out of range, literals, 18-byte overlapping copy,
    // folded offset in range, far offset, then a reference cut off at the end
    body_q = '{8'h63, 8'h25, 8'h3C, 8'hFF, 8'h5A, 8'h0F, 8'h00, 8'hF0, 8'hFF,
               8'h41, 8'h01, 8'h80, 8'h01, 8'h00, 8'h37};
    send_framed(1'b1);
    body_q = '{8'hFF};
    send_raw();
    body_q = '{8'h00, 8'h00};
    send_raw();
    body_q = '{8'h01, 8'h00, 8'hFF};
    send_raw();
  endtask

  task automatic test_output_limit();
    drain();
    set_limit(16'd0);
    build_body(6, 50, 0, 1'b0);
    send_framed(1'b1);
    drain();
    set_limit(16'd10);
    build_body(8, 60, 0, 1'b1);
    send_framed(1'b1);
  endtask

  // stream of long copies while the receiver holds off
  task automatic test_backpressure();
    drain();
    set_limit(16'hFFFF);
    tx_gaps = 1'b0;
    rx_gaps <= 1'b1;
    build_body(40, 95, 0, 1'b1);
    long_hold_req <= 1'b1;
    send_framed(1'b1);
  endtask

  task automatic test_random_streams();
    int kind, base, n, done_items;
    logic [15:0] lim;
    bit quiet_tail;
    base = sent_items;
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        drain();
        case ($urandom_range(0, 4))
          0: lim = 16'd0;
          1: lim = 16'hFFFF;
          2: lim = 16'($urandom_range(1, 40));
          default: lim = 16'($urandom_range(0, 65535));
        endcase
        set_limit(lim);
      end
      quiet_tail = done_items > RANDOM_ITEMS * 4 / 5;
      tx_gaps = !quiet_tail && $urandom_range(0, 3) != 0;
      rx_gaps <= !quiet_tail && $urandom_range(0, 3) != 0;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        build_body($urandom_range(1, 10), 50, 20, 1'b0);
        send_framed(1'b1);
      end else if (kind == 7) begin
        build_body($urandom_range(1, 10), 50, 20, 1'b0);
        send_framed(1'b0);
      end else if (kind == 8) begin
        // stream cut short anywhere, including inside a reference
        build_body($urandom_range(2, 10), 50, 20, 1'b0);
        n = $urandom_range(1, body_q.size());
        while (body_q.size() > n) void'(body_q.pop_back());
        send_framed(1'($urandom_range(0, 1)));
      end else begin
        body_q.delete();
        n = $urandom_range(1, 6);
        repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
        send_raw();
      end
      done_items = sent_items - base;
    end
  endtask

  initial begin
    clear_stream();
    out_limit = MAX_OUTPUT_DEF;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_output_limit();
    test_backpressure();
    test_random_streams();
    drain();
    if (mismatch_count == 0) $display("PASS lzss_byte_decompressor");
    else $display("FAIL lzss_byte_decompressor");
    $finish;
  end

endmodule
